[rtl/ifdd_pkg.sv]
// ----------------------------------------------------------------------------
// ifdd_pkg
// shared constants and types of the information frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package ifdd_pkg;

  localparam int MAX_PAYLOAD = 4096;

  // byte counter holds payload plus check byte, up to MAX_PAYLOAD + 1
  localparam int COUNT_W = $clog2(MAX_PAYLOAD + 2);
  localparam int LEN_W   = 13;
  localparam int KIND_W  = 3;
  localparam int REG_IDX_W = 3;
  localparam int REG_W   = 8;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK_FAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_ESCAPE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DISCONNECT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG   = 3'd5;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FLAG         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESC_FLAG     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ESC_ESCAPE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_EVEN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_ODD     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DISCONNECT   = 3'd7;

  // reset values of the configuration registers
  localparam logic [7:0] RST_FLAG       = 8'd126;
  localparam logic [7:0] RST_ESCAPE     = 8'd125;
  localparam logic [7:0] RST_ESC_FLAG   = 8'd94;
  localparam logic [7:0] RST_ESC_ESCAPE = 8'd93;
  localparam logic [7:0] RST_ADDRESS    = 8'd3;
  localparam logic [7:0] RST_CTRL_EVEN  = 8'd0;
  localparam logic [7:0] RST_CTRL_ODD   = 8'd128;
  localparam logic [7:0] RST_DISCONNECT = 8'd11;

  typedef struct packed {
    logic [KIND_W-1:0] out_kind;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  payload_length;
    logic              reply_seq;
  } result_t;

endpackage

`default_nettype wire

[rtl/ifdd_byte_if.sv]
// ----------------------------------------------------------------------------
// ifdd_byte_if
// received line byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface ifdd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/ifdd_result_if.sv]
// ----------------------------------------------------------------------------
// ifdd_result_if
// deframer result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface ifdd_result_if;
  logic                         valid;
  logic                         ready;
  logic [ifdd_pkg::KIND_W-1:0]  out_kind;
  logic [7:0]                   data_byte;
  logic [ifdd_pkg::LEN_W-1:0]   payload_length;
  logic                         reply_seq;

  modport source (output valid, output out_kind, output data_byte,
                  output payload_length, output reply_seq, input ready);
  modport sink   (input valid, input out_kind, input data_byte,
                  input payload_length, input reply_seq, output ready);
endinterface

`default_nettype wire

[rtl/info_frame_destuffing_deframer_core.sv]
// ----------------------------------------------------------------------------
// info_frame_destuffing_deframer_core
// byte-stuffed information frame receiver with header check and xor check
// ----------------------------------------------------------------------------
// a result caused by a byte enters the result queue at the byte's transfer and
//   shows on the result channel once the results ahead of it have left
// throughput: one byte per cycle, a single pass of compare and select logic;
//   a two-entry result queue keeps bytes flowing until it is full and no result leaves
// reset (synchronous, rst high): hunting for the opening flag, expected
//   sequence zero, result queue empty, registers back to their defaults
`default_nettype none

module info_frame_destuffing_deframer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ifdd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [ifdd_pkg::REG_W-1:0]      cfg_data,
  ifdd_byte_if.sink                            rx,
  ifdd_result_if.source                        res
);

  // receive phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_FLAG = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_ESC  = 3'd5;

  localparam logic [ifdd_pkg::COUNT_W-1:0] COUNT_LIMIT =
    ifdd_pkg::COUNT_W'(ifdd_pkg::MAX_PAYLOAD + 1);

  // configuration registers
  logic [7:0] flag_byte, escape_byte, escaped_flag_code, escaped_escape_code;
  logic [7:0] address_code, info_control_even, info_control_odd;
  logic [7:0] disconnect_control;

  // receive state
  logic [2:0]                      phase, phase_next;
  logic                            expected_seq, expected_seq_next;
  logic [7:0]                      running_xor, running_xor_next;
  logic [7:0]                      held_byte, held_byte_next;
  logic                            held_valid, held_valid_next;
  logic [ifdd_pkg::COUNT_W-1:0]    byte_count, byte_count_next;

  // result queue, slot 0 is the head
  ifdd_pkg::result_t               slot0, slot1;
  logic [1:0]                      fill;

  logic                            in_xfer, out_xfer;
  logic                            emit;
  ifdd_pkg::result_t               result;

  // per-byte decode helpers
  logic [7:0]                      ctrl;
  logic                            reply;
  logic                            body_go;
  logic [7:0]                      body_in;
  logic [ifdd_pkg::LEN_W-1:0]      frame_len;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte           <= ifdd_pkg::RST_FLAG;
      escape_byte         <= ifdd_pkg::RST_ESCAPE;
      escaped_flag_code   <= ifdd_pkg::RST_ESC_FLAG;
      escaped_escape_code <= ifdd_pkg::RST_ESC_ESCAPE;
      address_code        <= ifdd_pkg::RST_ADDRESS;
      info_control_even   <= ifdd_pkg::RST_CTRL_EVEN;
      info_control_odd    <= ifdd_pkg::RST_CTRL_ODD;
      disconnect_control  <= ifdd_pkg::RST_DISCONNECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifdd_pkg::REG_FLAG:       flag_byte           <= cfg_data;
        ifdd_pkg::REG_ESCAPE:     escape_byte         <= cfg_data;
        ifdd_pkg::REG_ESC_FLAG:   escaped_flag_code   <= cfg_data;
        ifdd_pkg::REG_ESC_ESCAPE: escaped_escape_code <= cfg_data;
        ifdd_pkg::REG_ADDRESS:    address_code        <= cfg_data;
        ifdd_pkg::REG_CTRL_EVEN:  info_control_even   <= cfg_data;
        ifdd_pkg::REG_CTRL_ODD:   info_control_odd    <= cfg_data;
        ifdd_pkg::REG_DISCONNECT: disconnect_control  <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a byte unless the queue is full and nothing leaves this cycle
  assign rx.ready = (fill != 2'd2) || res.ready;
  assign in_xfer  = rx.valid && rx.ready;
  assign out_xfer = res.valid && res.ready;

  assign ctrl      = expected_seq ? info_control_odd : info_control_even;
  assign reply     = ~expected_seq;
  // length excludes the trailing check byte
  assign frame_len = ifdd_pkg::LEN_W'(byte_count - 1'b1);

  // next state and result of one byte
  always_comb begin
    phase_next        = phase;
    expected_seq_next = expected_seq;
    running_xor_next  = running_xor;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    byte_count_next   = byte_count;
    emit              = 1'b0;
    result            = '0;
    body_go           = 1'b0;
    body_in           = rx.rx_byte;

    unique case (phase)
      PH_HUNT: begin
        if (rx.rx_byte == flag_byte) phase_next = PH_FLAG;
      end
      PH_FLAG: begin
        if (rx.rx_byte == address_code) phase_next = PH_ADDR;
        else if (rx.rx_byte != flag_byte) phase_next = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx.rx_byte == ctrl) begin
          phase_next = PH_CTRL;
        end else if (rx.rx_byte == flag_byte) begin
          phase_next = PH_FLAG;
        end else if (rx.rx_byte == disconnect_control) begin
          phase_next      = PH_HUNT;
          emit            = 1'b1;
          result.out_kind = ifdd_pkg::KIND_DISCONNECT;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_CTRL: begin
        // header check: address xor control
        if (rx.rx_byte == (address_code ^ ctrl)) begin
          phase_next       = PH_BODY;
          running_xor_next = '0;
          held_byte_next   = '0;
          held_valid_next  = 1'b0;
          byte_count_next  = '0;
        end else if (rx.rx_byte == flag_byte) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (rx.rx_byte == escape_byte) begin
          phase_next = PH_ESC;
        end else if (rx.rx_byte == flag_byte) begin
          // closing flag: report the frame verdict
          phase_next       = PH_HUNT;
          emit             = 1'b1;
          result.reply_seq = reply;
          if (byte_count == '0) begin
            // empty frame counts as a check failure
            result.out_kind = ifdd_pkg::KIND_CHECK_FAIL;
          end else if (running_xor == '0) begin
            expected_seq_next     = ~expected_seq;
            result.out_kind       = ifdd_pkg::KIND_ACCEPTED;
            result.payload_length = frame_len;
          end else begin
            result.out_kind       = ifdd_pkg::KIND_CHECK_FAIL;
            result.payload_length = frame_len;
          end
        end else begin
          body_go = 1'b1;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        if (rx.rx_byte == escaped_flag_code) begin
          body_go = 1'b1;
          body_in = flag_byte;
        end else if (rx.rx_byte == escaped_escape_code) begin
          body_go = 1'b1;
          body_in = escape_byte;
        end else begin
          phase_next       = PH_HUNT;
          emit             = 1'b1;
          result.out_kind  = ifdd_pkg::KIND_BAD_ESCAPE;
          result.reply_seq = reply;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    // destuffed body byte: pass the held byte out, hold the new one; at the limit report too long
    if (body_go) begin
      if (byte_count >= COUNT_LIMIT) begin
        phase_next      = PH_HUNT;
        emit            = 1'b1;
        result          = '0;
        result.out_kind = ifdd_pkg::KIND_TOO_LONG;
      end else begin
        if (held_valid) begin
          emit             = 1'b1;
          result.out_kind  = ifdd_pkg::KIND_DATA;
          result.data_byte = held_byte;
        end
        held_byte_next   = body_in;
        held_valid_next  = 1'b1;
        running_xor_next = running_xor ^ body_in;
        byte_count_next  = byte_count + 1'b1;
      end
    end
  end

  // receive state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      expected_seq <= 1'b0;
      running_xor  <= '0;
      held_byte    <= '0;
      held_valid   <= 1'b0;
      byte_count   <= '0;
    end else if (in_xfer) begin
      phase        <= phase_next;
      expected_seq <= expected_seq_next;
      running_xor  <= running_xor_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      byte_count   <= byte_count_next;
    end
  end

  // result queue: push on a byte transfer that emits, pop on a result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({in_xfer && emit, out_xfer})
        2'b11: fill <= fill;
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({in_xfer && emit, out_xfer})
      2'b11: begin
        if (fill == 2'd1) begin
          slot0 <= result;
        end else begin
          slot0 <= slot1;
          slot1 <= result;
        end
      end
      2'b10: begin
        if (fill == 2'd0) slot0 <= result;
        else slot1 <= result;
      end
      2'b01: begin
        slot0 <= slot1;
      end
      default: ;
    endcase
  end

  assign res.valid          = (fill != 2'd0);
  assign res.out_kind       = slot0.out_kind;
  assign res.data_byte      = slot0.data_byte;
  assign res.payload_length = slot0.payload_length;
  assign res.reply_seq      = slot0.reply_seq;

endmodule

`default_nettype wire

[sim/deframer_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_result_checker
// watches the line byte and result channels, predicts the deframer output
// from its own copy of state and registers, and compares every result
// ----------------------------------------------------------------------------
module deframer_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ifdd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ifdd_pkg::REG_W-1:0]     cfg_data,
  ifdd_byte_if                           rx,
  ifdd_result_if                         res,
  output int                             fail_count,
  output int                             pending,
  output logic                           next_seq
);

  typedef enum logic [2:0] {
    ST_HUNT, ST_FLAG, ST_ADDR, ST_CTRL, ST_BODY, ST_ESC
  } rx_state_t;

  logic [7:0]        regs [8];
  rx_state_t         state;
  logic              seq;
  logic [7:0]        sum;
  logic [7:0]        held;
  logic              held_v;
  int unsigned       body_count;
  ifdd_pkg::result_t expected_results [$];
  ifdd_pkg::result_t want;

  task automatic queue_result(input logic [ifdd_pkg::KIND_W-1:0] kind,
                              input logic [7:0] data,
                              input int unsigned len, input logic seq_bit);
    ifdd_pkg::result_t r;
    r.out_kind       = kind;
    r.data_byte      = data;
    r.payload_length = ifdd_pkg::LEN_W'(len);
    r.reply_seq      = seq_bit;
    expected_results.push_back(r);
  endtask

  // destuffed body byte: the previous one goes out, this one is held back; at the limit report too long
  task automatic take_body_byte(input logic [7:0] b);
    if (body_count >= ifdd_pkg::MAX_PAYLOAD + 1) begin
      state = ST_HUNT;
      queue_result(ifdd_pkg::KIND_TOO_LONG, '0, 0, 1'b0);
    end else begin
      if (held_v) queue_result(ifdd_pkg::KIND_DATA, held, 0, 1'b0);
      held   = b;
      held_v = 1'b1;
      sum    = sum ^ b;
      body_count++;
    end
  endtask

  task automatic predict_line_byte(input logic [7:0] b);
    logic [7:0] ctrl;
    logic       reply;
    ctrl  = seq ? regs[ifdd_pkg::REG_CTRL_ODD] : regs[ifdd_pkg::REG_CTRL_EVEN];
    reply = ~seq;
    case (state)
      ST_HUNT: begin
        if (b == regs[ifdd_pkg::REG_FLAG]) state = ST_FLAG;
      end
      ST_FLAG: begin
        if (b == regs[ifdd_pkg::REG_ADDRESS]) state = ST_ADDR;
        else if (b != regs[ifdd_pkg::REG_FLAG]) state = ST_HUNT;
      end
      ST_ADDR: begin
        if (b == ctrl) state = ST_CTRL;
        else if (b == regs[ifdd_pkg::REG_FLAG]) state = ST_FLAG;
        else if (b == regs[ifdd_pkg::REG_DISCONNECT]) begin
          state = ST_HUNT;
          queue_result(ifdd_pkg::KIND_DISCONNECT, '0, 0, 1'b0);
        end else state = ST_HUNT;
      end
      ST_CTRL: begin
        if (b == (regs[ifdd_pkg::REG_ADDRESS] ^ ctrl)) begin
          state      = ST_BODY;
          sum        = '0;
          held       = '0;
          held_v     = 1'b0;
          body_count = 0;
        end else if (b == regs[ifdd_pkg::REG_FLAG]) state = ST_FLAG;
        else state = ST_HUNT;
      end
      ST_BODY: begin
        if (b == regs[ifdd_pkg::REG_ESCAPE]) state = ST_ESC;
        else if (b == regs[ifdd_pkg::REG_FLAG]) begin
          state = ST_HUNT;
          if (body_count == 0) queue_result(ifdd_pkg::KIND_CHECK_FAIL, '0, 0, reply);
          else if (sum == '0) begin
            queue_result(ifdd_pkg::KIND_ACCEPTED, '0, body_count - 1, reply);
            seq = ~seq;
          end else queue_result(ifdd_pkg::KIND_CHECK_FAIL, '0, body_count - 1, reply);
        end else take_body_byte(b);
      end
      ST_ESC: begin
        state = ST_BODY;
        if (b == regs[ifdd_pkg::REG_ESC_FLAG]) take_body_byte(regs[ifdd_pkg::REG_FLAG]);
        else if (b == regs[ifdd_pkg::REG_ESC_ESCAPE])
          take_body_byte(regs[ifdd_pkg::REG_ESCAPE]);
        else begin
          state = ST_HUNT;
          queue_result(ifdd_pkg::KIND_BAD_ESCAPE, '0, 0, reply);
        end
      end
      default: state = ST_HUNT;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs[ifdd_pkg::REG_FLAG]       = ifdd_pkg::RST_FLAG;
      regs[ifdd_pkg::REG_ESCAPE]     = ifdd_pkg::RST_ESCAPE;
      regs[ifdd_pkg::REG_ESC_FLAG]   = ifdd_pkg::RST_ESC_FLAG;
      regs[ifdd_pkg::REG_ESC_ESCAPE] = ifdd_pkg::RST_ESC_ESCAPE;
      regs[ifdd_pkg::REG_ADDRESS]    = ifdd_pkg::RST_ADDRESS;
      regs[ifdd_pkg::REG_CTRL_EVEN]  = ifdd_pkg::RST_CTRL_EVEN;
      regs[ifdd_pkg::REG_CTRL_ODD]   = ifdd_pkg::RST_CTRL_ODD;
      regs[ifdd_pkg::REG_DISCONNECT] = ifdd_pkg::RST_DISCONNECT;
      state      = ST_HUNT;
      seq        = 1'b0;
      sum        = '0;
      held       = '0;
      held_v     = 1'b0;
      body_count = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // results first: a byte taken at this edge cannot show up before the next one
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: out_kind %0d", res.out_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_kind", 16'(want.out_kind), 16'(res.out_kind));
          compare_field("data_byte", 16'(want.data_byte), 16'(res.data_byte));
          compare_field("payload_length", 16'(want.payload_length),
                        16'(res.payload_length));
          compare_field("reply_seq", 16'(want.reply_seq), 16'(res.reply_seq));
        end
      end
      if (cfg_we) regs[cfg_index] = cfg_data;
      if (rx.valid && rx.ready) predict_line_byte(rx.rx_byte);
    end
    pending  = expected_results.size();
    next_seq = seq;
  end

endmodule

[sim/tb_info_frame_destuffing_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_info_frame_destuffing_deframer_core
// drives line bytes built as well-formed, damaged and noisy frames through
// the deframer under several register settings, with random stalls on both
// channels; the checker beside the block predicts and compares the results
// ----------------------------------------------------------------------------
module tb_info_frame_destuffing_deframer_core;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 1400;
  localparam int PHASES         = 5;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_WAIT       = 16;

  typedef logic [7:0] byte_list_t [$];
  typedef logic [7:0] reg_set_t [8];

  // what a generated frame is meant to exercise
  typedef enum {
    FR_GOOD, FR_BAD_CHECK, FR_WRONG_SEQ, FR_EMPTY, FR_BAD_ESC, FR_DISC,
    FR_BROKEN_HDR, FR_NOISE
  } frame_kind_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [ifdd_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [ifdd_pkg::REG_W-1:0]     cfg_data = '0;

  ifdd_byte_if   rx ();
  ifdd_result_if res ();

  int   fail_count;
  int   pending;
  logic next_seq;

  // set for stretches where neither side idles
  bit   no_idle = 1'b0;
  int   line_bytes = 0;
  int   idle_cycles = 0;
  // register values as last written, used to build frames
  logic [7:0] cfg_shadow [8];

  info_frame_destuffing_deframer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res)
  );

  deframer_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending),
    .next_seq   (next_seq)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // random byte, often one of the configured special values
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return cfg_shadow[$urandom_range(0, 7)];
    return 8'($urandom());
  endfunction

  // result side: random stall before each transfer
  initial begin
    int stall;
    res.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready = 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one line byte transfer; starts and ends at a falling edge
  task automatic send_line_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      rx.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx.valid   = 1'b1;
    rx.rx_byte = b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    @(negedge clk);
    line_bytes++;
  endtask

  // escape stuffing of one body byte
  task automatic stuff_byte(input logic [7:0] d);
    if (d == cfg_shadow[ifdd_pkg::REG_ESCAPE]) begin
      send_line_byte(cfg_shadow[ifdd_pkg::REG_ESCAPE]);
      send_line_byte(cfg_shadow[ifdd_pkg::REG_ESC_ESCAPE]);
    end else if (d == cfg_shadow[ifdd_pkg::REG_FLAG]) begin
      send_line_byte(cfg_shadow[ifdd_pkg::REG_ESCAPE]);
      send_line_byte(cfg_shadow[ifdd_pkg::REG_ESC_FLAG]);
    end else begin
      send_line_byte(d);
    end
  endtask

  task automatic send_frame(input frame_kind_t kind, input byte_list_t payload);
    logic [7:0] ctrl;
    logic [7:0] sum;
    logic [7:0] code;
    int         cut;
    // wrong sequence frames carry the control byte of the other sequence
    ctrl = (next_seq ^ (kind == FR_WRONG_SEQ)) ? cfg_shadow[ifdd_pkg::REG_CTRL_ODD]
                                                 : cfg_shadow[ifdd_pkg::REG_CTRL_EVEN];
    sum  = '0;
    if (kind == FR_NOISE) begin
      foreach (payload[i]) send_line_byte(payload[i]);
      return;
    end
    send_line_byte(cfg_shadow[ifdd_pkg::REG_FLAG]);
    if (kind == FR_BROKEN_HDR) begin
      // repeated flags, header cut short, then a stray byte
      repeat ($urandom_range(0, 2)) send_line_byte(cfg_shadow[ifdd_pkg::REG_FLAG]);
      cut = $urandom_range(0, 2);
      if (cut >= 1) send_line_byte(cfg_shadow[ifdd_pkg::REG_ADDRESS]);
      if (cut >= 2) send_line_byte(ctrl);
      send_line_byte(pick_byte());
      return;
    end
    send_line_byte(cfg_shadow[ifdd_pkg::REG_ADDRESS]);
    if (kind == FR_DISC) begin
      send_line_byte(cfg_shadow[ifdd_pkg::REG_DISCONNECT]);
      return;
    end
    send_line_byte(ctrl);
    send_line_byte(cfg_shadow[ifdd_pkg::REG_ADDRESS] ^ ctrl);
    if (kind == FR_EMPTY) begin
      send_line_byte(cfg_shadow[ifdd_pkg::REG_FLAG]);
      return;
    end
    foreach (payload[i]) begin
      stuff_byte(payload[i]);
      sum = sum ^ payload[i];
    end
    if (kind == FR_BAD_ESC) begin
      // escape followed by neither code
      send_line_byte(cfg_shadow[ifdd_pkg::REG_ESCAPE]);
      code = pick_byte();
      while (code == cfg_shadow[ifdd_pkg::REG_ESC_FLAG] ||
             code == cfg_shadow[ifdd_pkg::REG_ESC_ESCAPE])
        code = 8'($urandom());
      send_line_byte(code);
      return;
    end
    if (kind == FR_BAD_CHECK) sum = sum ^ 8'($urandom_range(1, 255));
    stuff_byte(sum);
    send_line_byte(cfg_shadow[ifdd_pkg::REG_FLAG]);
  endtask

  task automatic send_random_frame();
    int          r;
    int          plen;
    byte_list_t  pl;
    frame_kind_t kind;
    if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
    r = $urandom_range(0, 99);
    if (r < 45)      kind = FR_GOOD;
    else if (r < 55) kind = FR_BAD_CHECK;
    else if (r < 62) kind = FR_WRONG_SEQ;
    else if (r < 68) kind = FR_EMPTY;
    else if (r < 75) kind = FR_BAD_ESC;
    else if (r < 81) kind = FR_DISC;
    else if (r < 90) kind = FR_BROKEN_HDR;
    else             kind = FR_NOISE;
    // mostly short payloads, now and then a longer one
    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    if (kind == FR_NOISE) plen = $urandom_range(1, 8);
    repeat (plen) pl.push_back(pick_byte());
    send_frame(kind, pl);
  endtask

  // register writes only once the block has nothing left in flight
  task automatic load_registers(input reg_set_t v);
    rx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we        = 1'b1;
      cfg_index     = ifdd_pkg::REG_IDX_W'(i);
      cfg_data      = v[i];
      cfg_shadow[i] = v[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic random_registers();
    reg_set_t v;
    foreach (v[i]) v[i] = 8'($urandom());
    load_registers(v);
  endtask

  initial begin
    byte_list_t pl;
    reg_set_t   extreme_lo;
    reg_set_t   extreme_hi;
    int         target;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    cfg_shadow[ifdd_pkg::REG_FLAG]       = ifdd_pkg::RST_FLAG;
    cfg_shadow[ifdd_pkg::REG_ESCAPE]     = ifdd_pkg::RST_ESCAPE;
    cfg_shadow[ifdd_pkg::REG_ESC_FLAG]   = ifdd_pkg::RST_ESC_FLAG;
    cfg_shadow[ifdd_pkg::REG_ESC_ESCAPE] = ifdd_pkg::RST_ESC_ESCAPE;
    cfg_shadow[ifdd_pkg::REG_ADDRESS]    = ifdd_pkg::RST_ADDRESS;
    cfg_shadow[ifdd_pkg::REG_CTRL_EVEN]  = ifdd_pkg::RST_CTRL_EVEN;
    cfg_shadow[ifdd_pkg::REG_CTRL_ODD]   = ifdd_pkg::RST_CTRL_ODD;
    cfg_shadow[ifdd_pkg::REG_DISCONNECT] = ifdd_pkg::RST_DISCONNECT;
    extreme_lo = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
    extreme_hi = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: data extremes plus both stuffed values in one good frame
    pl = {8'h00, 8'hFF, cfg_shadow[ifdd_pkg::REG_FLAG], cfg_shadow[ifdd_pkg::REG_ESCAPE]};
    send_frame(FR_GOOD, pl);
    // empty frame, bad escape, disconnect request
    pl.delete();
    send_frame(FR_EMPTY, pl);
    send_frame(FR_BAD_ESC, pl);
    send_frame(FR_DISC, pl);

    // random phases under reset values, random values and both extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: random_registers();
        2: load_registers(extreme_lo);
        3: load_registers(extreme_hi);
        4: random_registers();
        // first phase keeps the reset values
        default: ;
      endcase
      target = line_bytes + RANDOM_BYTES / PHASES;
      while (line_bytes < target) send_random_frame();
    end

    // let the last results drain, then a few more cycles for stray output
    rx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ifdd_pkg.sv
rtl/ifdd_byte_if.sv
rtl/ifdd_result_if.sv
rtl/info_frame_destuffing_deframer_core.sv
sim/deframer_result_checker.sv
sim/tb_info_frame_destuffing_deframer_core.sv
